/* rtl/lhtu_pkg.sv */
// Shared types, codes and sizes of the linear-probing hash table unit.
package lhtu_pkg;

  // Number of slots; a power of two, so the home slot is the low hash bits.
  localparam int unsigned TableSize = 512;
  localparam int unsigned SlotW     = $clog2(TableSize);
  // Longest key in bytes.
  localparam int unsigned KeyBytes  = 8;
  localparam int unsigned ByteCntW  = $clog2(KeyBytes + 1);

  typedef enum logic [1:0] {
    OpLookup = 2'd0,
    OpInsert = 2'd1,
    OpDelete = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2
  } status_e;

  // Slot mark codes; code 3 is never written and reads like a tombstone.
  localparam logic [1:0] MarkEmpty = 2'd0;
  localparam logic [1:0] MarkFull  = 2'd1;
  localparam logic [1:0] MarkTomb  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_word;
    logic [63:0] value_word;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value_out;
    logic [8:0]  slot_index;
  } out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_e              op;
    logic [63:0]      norm;
    logic [63:0]      value;
    logic [SlotW-1:0] home;
  } cmd_t;

  typedef enum logic [1:0] {
    FIdle,
    FHash,
    FPush
  } front_state_e;

  typedef enum logic [1:0] {
    BInit,
    BIdle,
    BProbe,
    BClear
  } back_state_e;

endpackage

/* rtl/lhtu_front.sv */
// Front end: accepts items, hashes and normalises the key, queues a command.
module lhtu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  lhtu_pkg::in_t      req_i,
  input  logic               init_busy_i,
  output logic               cmd_valid_o,
  input  logic               cmd_full_i,
  output lhtu_pkg::cmd_t     cmd_o
);

  lhtu_pkg::front_state_e state_q, state_d;
  lhtu_pkg::in_t          in_q, in_d;
  logic [63:0]            rest_q, rest_d;
  logic [63:0]            norm_q, norm_d;
  logic [31:0]            hash_q, hash_d;
  logic [lhtu_pkg::ByteCntW-1:0] cnt_q, cnt_d;
  logic [7:0]             cur_byte;
  logic                   key_end;

  assign cur_byte = rest_q[63:56];
  assign key_end  = (cur_byte == 8'd0) ||
                    (cnt_q == lhtu_pkg::ByteCntW'(lhtu_pkg::KeyBytes));

  assign full = (state_q != lhtu_pkg::FIdle) || init_busy_i;

  // Build the command from the hashed item
  assign cmd_o.op    = lhtu_pkg::op_e'(in_q.opcode);
  assign cmd_o.norm  = norm_q;
  assign cmd_o.value = in_q.value_word;
  assign cmd_o.home  = hash_q[lhtu_pkg::SlotW-1:0];
  assign cmd_valid_o = (state_q == lhtu_pkg::FPush);

  // Next state: take an item, hash one byte a cycle, hand it over
  always_comb begin
    state_d = state_q;
    in_d    = in_q;
    rest_d  = rest_q;
    norm_d  = norm_q;
    hash_d  = hash_q;
    cnt_d   = cnt_q;
    case (state_q)
      lhtu_pkg::FIdle: begin
        if (push && !full) begin
          in_d   = req_i;
          rest_d = req_i.key_word;
          norm_d = '0;
          hash_d = '0;
          cnt_d  = '0;
          if (lhtu_pkg::op_e'(req_i.opcode) == lhtu_pkg::OpClear) begin
            state_d = lhtu_pkg::FPush;
          end else begin
            state_d = lhtu_pkg::FHash;
          end
        end
      end
      lhtu_pkg::FHash: begin
        if (key_end) begin
          state_d = lhtu_pkg::FPush;
        end else begin
          hash_d = ((hash_q << 5) - hash_q) ^ {24'd0, cur_byte};
          norm_d = {norm_q[55:0], cur_byte};
          rest_d = {rest_q[55:0], 8'd0};
          cnt_d  = cnt_q + 1'b1;
        end
      end
      lhtu_pkg::FPush: begin
        // Hold the command until the queue takes it
        if (!cmd_full_i) begin
          state_d = lhtu_pkg::FIdle;
        end
      end
      default: state_d = lhtu_pkg::FIdle;
    endcase
    // Shift collected bytes to the top when the key ends
    if (state_q == lhtu_pkg::FHash && key_end) begin
      norm_d = norm_q << {cnt_q == '0 ? 6'd0 : 6'(8 * (8 - int'(cnt_q)))};
      if (cnt_q == '0) norm_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lhtu_pkg::FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    rest_q <= rest_d;
    norm_q <= norm_d;
    hash_q <= hash_d;
    cnt_q  <= cnt_d;
  end

endmodule

/* rtl/lhtu_cmd_fifo.sv */
// Two-entry command queue between the front and the back.
module lhtu_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  lhtu_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           valid_o,
  output lhtu_pkg::cmd_t rd_data_o
);

  lhtu_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en_i} - {1'b0, rd_en_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

/* rtl/lhtu_back.sv */
// Back end: probes the slot memories, sweeps them clear, holds the result.
module lhtu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  lhtu_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           init_busy_o,
  output logic           empty,
  input  logic           pop,
  output lhtu_pkg::out_t rsp_o
);

  localparam logic [lhtu_pkg::SlotW-1:0] LastSlot =
    lhtu_pkg::SlotW'(lhtu_pkg::TableSize - 1);

  // Slot memories
  logic [1:0]  mark_mem [lhtu_pkg::TableSize];
  logic [63:0] key_mem  [lhtu_pkg::TableSize];
  logic [63:0] val_mem  [lhtu_pkg::TableSize];

  lhtu_pkg::back_state_e        state_q, state_d;
  lhtu_pkg::cmd_t               cur_q, cur_d;
  logic [lhtu_pkg::SlotW-1:0]   probe_q, probe_d;
  logic [lhtu_pkg::SlotW-1:0]   cnt_q, cnt_d;
  logic [lhtu_pkg::SlotW-1:0]   clr_q, clr_d;
  logic [1:0]                   mark_rd_q;
  logic [63:0]                  key_rd_q, val_rd_q;
  logic                         mark_we, kv_we;
  logic [lhtu_pkg::SlotW-1:0]   wr_addr;
  logic [1:0]                   mark_wd;
  logic                         res_we;
  lhtu_pkg::out_t               res_d, out_q;
  logic                         out_valid_q;

  assign init_busy_o = (state_q == lhtu_pkg::BInit);
  assign empty       = !out_valid_q;
  assign rsp_o       = out_q;

  // Sequence probes and clearing sweeps
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    probe_d   = probe_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    cmd_pop_o = 1'b0;
    mark_we   = 1'b0;
    kv_we     = 1'b0;
    wr_addr   = probe_q;
    mark_wd   = lhtu_pkg::MarkEmpty;
    res_we    = 1'b0;
    res_d     = '0;
    case (state_q)
      lhtu_pkg::BInit, lhtu_pkg::BClear: begin
        mark_we = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          state_d = lhtu_pkg::BIdle;
          res_we  = (state_q == lhtu_pkg::BClear);
          res_d.status = lhtu_pkg::StOk;
        end
      end
      lhtu_pkg::BIdle: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          clr_d     = '0;
          probe_d   = cmd_i.home;
          cnt_d     = '0;
          if (cmd_i.op == lhtu_pkg::OpClear) begin
            state_d = lhtu_pkg::BClear;
          end else begin
            state_d = lhtu_pkg::BProbe;
          end
        end
      end
      lhtu_pkg::BProbe: begin
        if (cur_q.op == lhtu_pkg::OpInsert) begin
          if (mark_rd_q != lhtu_pkg::MarkFull) begin
            mark_we = 1'b1;
            kv_we   = 1'b1;
            mark_wd = lhtu_pkg::MarkFull;
            res_we  = 1'b1;
            res_d.status     = lhtu_pkg::StOk;
            res_d.slot_index = 9'(probe_q);
            state_d = lhtu_pkg::BIdle;
          end else if (cnt_q == LastSlot) begin
            res_we  = 1'b1;
            res_d.status = lhtu_pkg::StFull;
            state_d = lhtu_pkg::BIdle;
          end else begin
            probe_d = probe_q + 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end
        end else begin
          if (mark_rd_q == lhtu_pkg::MarkEmpty) begin
            res_we  = 1'b1;
            res_d.status = lhtu_pkg::StMiss;
            state_d = lhtu_pkg::BIdle;
          end else if (mark_rd_q == lhtu_pkg::MarkFull && key_rd_q == cur_q.norm) begin
            mark_we = (cur_q.op == lhtu_pkg::OpDelete);
            mark_wd = lhtu_pkg::MarkTomb;
            res_we  = 1'b1;
            res_d.status     = lhtu_pkg::StOk;
            res_d.value_out  = val_rd_q;
            res_d.slot_index = 9'(probe_q);
            state_d = lhtu_pkg::BIdle;
          end else if (cnt_q == LastSlot) begin
            res_we  = 1'b1;
            res_d.status = lhtu_pkg::StMiss;
            state_d = lhtu_pkg::BIdle;
          end else begin
            probe_d = probe_q + 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = lhtu_pkg::BIdle;
    endcase
  end

  // Read at the next probe address, write at the current one
  always_ff @(posedge clk_i) begin
    mark_rd_q <= mark_mem[probe_d];
    key_rd_q  <= key_mem[probe_d];
    val_rd_q  <= val_mem[probe_d];
    if (mark_we) mark_mem[wr_addr] <= mark_wd;
    if (kv_we) begin
      key_mem[wr_addr] <= cur_q.norm;
      val_mem[wr_addr] <= cur_q.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhtu_pkg::BInit;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    probe_q <= probe_d;
    cnt_q   <= cnt_d;
    if (res_we) out_q <= res_d;
  end

  // A new result never lands on one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_we |-> !out_valid_q)
    else $error("result overwritten");
  // No command is taken during the power-up sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lhtu_pkg::BInit) |-> !cmd_pop_o)
    else $error("command taken during init sweep");
  // Key and data are written only together with an occupied mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kv_we |-> (mark_we && mark_wd == lhtu_pkg::MarkFull))
    else $error("slot data written without mark");

endmodule

/* rtl/linear_probe_hash_table_unit.sv */
// Top level of the linear-probing hash table unit.
//
//  channel   handshake        payload                 accepted when
//  request   push / full      req_i  (lhtu_pkg::in_t)  push && !full
//  result    empty / pop      rsp_o  (lhtu_pkg::out_t) pop && !empty
//
// Front: takes an item, hashes a key byte a cycle (up to 8), sees the key end,
// then holds the command until the queue takes it; clear skips the hashing.
// Back: fetches the command, then reads one slot a cycle while probing, up to
// all 512; clear sweeps all 512 slots, one slot a cycle.
// After reset all 512 slot marks are swept empty; full stays high meanwhile.
// A waiting result stalls the back; the front still fills the queue of two.
module linear_probe_hash_table_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  lhtu_pkg::in_t  req_i,
  output logic           empty,
  input  logic           pop,
  output lhtu_pkg::out_t rsp_o
);

  logic           front_valid, fifo_full, fifo_valid, fifo_pop, init_busy;
  lhtu_pkg::cmd_t front_cmd, fifo_cmd;

  lhtu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .init_busy_i (init_busy),
    .cmd_valid_o (front_valid),
    .cmd_full_i  (fifo_full),
    .cmd_o       (front_cmd)
  );

  lhtu_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_valid && !fifo_full),
    .wr_data_i (front_cmd),
    .full_o    (fifo_full),
    .rd_en_i   (fifo_pop),
    .valid_o   (fifo_valid),
    .rd_data_o (fifo_cmd)
  );

  lhtu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (fifo_cmd),
    .cmd_pop_o   (fifo_pop),
    .init_busy_o (init_busy),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule
